// File: hdl/ertt_pkg.sv
package ertt_pkg;

	localparam int RULE_SLOTS = 16;
	localparam int SLOT_W = $clog2(RULE_SLOTS);
	localparam int CNT_W = $clog2(RULE_SLOTS + 1);
	localparam int QDEPTH = 2;
	localparam int REC_W = 16 + 64 + 8 + 16 + 3 + 32 + 8;

	typedef enum logic [2:0] {
		REQ_ADD    = 3'd0,
		REQ_EDIT   = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_EVENT  = 3'd3,
		REQ_TICK   = 3'd4
	} req_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FIRED    = 3'd3;
	localparam logic [2:0] ST_TICK     = 3'd4;

	localparam logic [2:0] OP_EQ = 3'd0;
	localparam logic [2:0] OP_GT = 3'd1;
	localparam logic [2:0] OP_LT = 3'd2;
	localparam logic [2:0] OP_GE = 3'd3;
	localparam logic [2:0] OP_LE = 3'd4;

	typedef struct packed {
		logic [15:0] rule_id;
		logic [63:0] dev_addr;
		logic [7:0]  endpoint;
		logic [15:0] attr_code;
		logic [2:0]  op_code;
		logic [31:0] threshold;
		logic [7:0]  action_type;
	} rule_t;

	typedef struct packed {
		req_t        req;
		rule_t       rule;
		logic [31:0] sample;
	} cmd_t;

	function automatic logic rule_cmp(logic [2:0] op, logic signed [31:0] a,
			logic signed [31:0] b);
		logic r;
		begin
			case (op)
				OP_EQ: r = (a == b);
				OP_GT: r = (a > b);
				OP_LT: r = (a < b);
				OP_GE: r = (a >= b);
				OP_LE: r = (a <= b);
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

endpackage

// File: hdl/ertt_ram.sv
module ertt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/ertt_front.sv
module ertt_front import ertt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        cmd,
	output logic        busy,
	input  logic        pop,
	output logic        q_valid,
	output cmd_t        q_cmd
);
	cmd_t       q_mem_q [QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	// Unused request codes are dropped here and never reach the back end.
	assign busy = (fill_q == 2'(QDEPTH));
	assign push = start && !busy && (cmd.req inside {REQ_ADD, REQ_EDIT, REQ_REMOVE,
		REQ_EVENT, REQ_TICK});
	assign q_valid = (fill_q != 2'd0);
	assign q_cmd = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'(QDEPTH)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'(QDEPTH)) |-> !push) else $error("push while full");
endmodule

// File: hdl/ertt_back.sv
module ertt_back import ertt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  holdoff_ticks,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [15:0] fired_id,
	output logic [7:0]  fired_action,
	output logic        last
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIND  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_SCAN  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	cmd_t              cur_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [7:0]        hold_q [RULE_SLOTS];

	logic              we;
	logic [SLOT_W-1:0] waddr, raddr;
	rule_t             wdata, rdata;
	logic [REC_W-1:0]  rdata_raw;

	ertt_ram #(.WIDTH(REC_W), .DEPTH(RULE_SLOTS)) u_rules (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_raw)
	);
	assign rdata = rule_t'(rdata_raw);

	logic [SLOT_W-1:0] idx_s;
	logic [SLOT_W-1:0] nxt_s;
	logic              fire;
	assign idx_s = idx_q[SLOT_W-1:0];
	assign nxt_s = SLOT_W'(idx_q + 1'b1);
	assign fire = (hold_q[idx_s] == 8'd0) && (rdata.dev_addr == cur_q.rule.dev_addr)
		&& (rdata.endpoint == cur_q.rule.endpoint)
		&& (rdata.attr_code == cur_q.rule.attr_code)
		&& rule_cmp(rdata.op_code, cur_q.sample, rdata.threshold);

	always_comb begin
		we = 1'b0;
		waddr = idx_s;
		wdata = cur_q.rule;
		raddr = idx_s;
		pop = (state_q == S_IDLE) && q_valid;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid && q_cmd.req == REQ_ADD && count_q < CNT_W'(RULE_SLOTS)) begin
					we = 1'b1;
					waddr = count_q[SLOT_W-1:0];
					wdata = q_cmd.rule;
				end
				raddr = '0;
			end
			S_FIND: begin
				if (rdata.rule_id == cur_q.rule.rule_id && cur_q.req == REQ_EDIT)
					we = 1'b1;
				raddr = nxt_s;
			end
			S_SHIFT: begin
				// Read of the next slot landed last cycle; write it one down.
				we = 1'b1;
				wdata = rdata;
				raddr = SLOT_W'(idx_q + 2'd2);
			end
			S_SCAN: raddr = idx_s;
			S_CHECK: raddr = nxt_s;
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			strobe <= 1'b0;
			status <= ST_OK;
			fired_id <= '0;
			fired_action <= '0;
			last <= 1'b0;
			for (int i = 0; i < RULE_SLOTS; i++)
				hold_q[i] <= 8'd0;
		end else begin
			strobe <= 1'b0;
			status <= ST_OK;
			fired_id <= '0;
			fired_action <= '0;
			last <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (q_valid) begin
						unique case (q_cmd.req)
							REQ_ADD: begin
								strobe <= 1'b1;
								last <= 1'b1;
								if (count_q < CNT_W'(RULE_SLOTS)) begin
									hold_q[count_q[SLOT_W-1:0]] <= 8'd0;
									count_q <= count_q + 1'b1;
								end else
									status <= ST_FULL;
							end
							REQ_EDIT, REQ_REMOVE: begin
								if (count_q == '0) begin
									strobe <= 1'b1;
									last <= 1'b1;
									status <= ST_NOTFOUND;
								end else
									state_q <= S_FIND;
							end
							REQ_EVENT: begin
								if (count_q == '0) begin
									strobe <= 1'b1;
									last <= 1'b1;
								end else
									state_q <= S_CHECK;
							end
							REQ_TICK: begin
								strobe <= 1'b1;
								last <= 1'b1;
								status <= ST_TICK;
								for (int i = 0; i < RULE_SLOTS; i++)
									if (hold_q[i] != 8'd0)
										hold_q[i] <= hold_q[i] - 8'd1;
							end
							default: ;
						endcase
					end
				end
				S_FIND: begin
					if (rdata.rule_id == cur_q.rule.rule_id) begin
						if (cur_q.req == REQ_EDIT) begin
							hold_q[idx_s] <= 8'd0;
							strobe <= 1'b1;
							last <= 1'b1;
							state_q <= S_IDLE;
						end else if (idx_q + 1'b1 < count_q) begin
							state_q <= S_SHIFT;
						end else begin
							count_q <= count_q - 1'b1;
							strobe <= 1'b1;
							last <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (idx_q + 1'b1 < count_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						strobe <= 1'b1;
						last <= 1'b1;
						status <= ST_NOTFOUND;
						state_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					hold_q[idx_s] <= hold_q[nxt_s];
					if (idx_q + 2'd2 < count_q)
						idx_q <= idx_q + 1'b1;
					else begin
						count_q <= count_q - 1'b1;
						strobe <= 1'b1;
						last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: state_q <= S_CHECK;
				S_CHECK: begin
					if (fire) begin
						hold_q[idx_s] <= holdoff_ticks;
						strobe <= 1'b1;
						status <= ST_FIRED;
						fired_id <= rdata.rule_id;
						fired_action <= rdata.action_type;
					end
					if (idx_q + 1'b1 < count_q)
						idx_q <= idx_q + 1'b1;
					else
						state_q <= S_DONE;
				end
				S_DONE: begin
					strobe <= 1'b1;
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RULE_SLOTS)) else $error("rule count out of range");
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without strobe");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE) else $error("pop while working");
	a_fired_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_FIRED) |-> !last) else $error("fired result marked last");
endmodule

// File: hdl/event_rule_trigger_table_top.sv
// Trigger-rule table with holdoff.
// Requests enter on start with the fields on their own ports; a request is
// taken at a clock edge where start is high and busy is low. A two-entry
// queue sits between the request decoder and the rule engine, so busy is
// only high while both entries are occupied.
// Results come out on strobe, one cycle each, with last on the final one.
// Add, tick, and a request that finds the table empty answer from the idle
// state as the request leaves the queue. Edit and remove search the table
// one rule per cycle and remove then shifts the tail one rule per cycle.
// An event checks one rule per cycle through the single read port of the
// rule RAM; its final result comes from the done state after the last
// rule is checked.
// The rule engine takes the next request from the queue only when it is
// back in its idle state.
// The receiver cannot stall; results are never held.
// holdoff_ticks is written through cfg_we/cfg_wdata and resets to 3.
// Reset empties the table and the queue and clears every holdoff.
module event_rule_trigger_table_top import ertt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [15:0] rule_id,
	input  logic [63:0] dev_addr,
	input  logic [7:0]  endpoint,
	input  logic [15:0] attr_code,
	input  logic [2:0]  op_code,
	input  logic [31:0] threshold,
	input  logic [7:0]  action_type,
	input  logic [31:0] sample,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [15:0] fired_id,
	output logic [7:0]  fired_action,
	output logic        last
);
	logic [7:0] holdoff_q;
	cmd_t       cmd, q_cmd;
	logic       q_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			holdoff_q <= 8'd3;
		else if (cfg_we)
			holdoff_q <= cfg_wdata;
	end

	always_comb begin
		cmd.req = req_t'(req_type);
		cmd.rule.rule_id = rule_id;
		cmd.rule.dev_addr = dev_addr;
		cmd.rule.endpoint = endpoint;
		cmd.rule.attr_code = attr_code;
		cmd.rule.op_code = op_code;
		cmd.rule.threshold = threshold;
		cmd.rule.action_type = action_type;
		cmd.sample = sample;
	end

	ertt_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
	);

	ertt_back u_back (
		.clk(clk), .arst_n(arst_n), .holdoff_ticks(holdoff_q),
		.q_valid(q_valid), .q_cmd(q_cmd), .pop(pop), .strobe(strobe),
		.status(status), .fired_id(fired_id), .fired_action(fired_action),
		.last(last)
	);
endmodule

// File: bench/tb_event_rule_trigger_table_top.sv
`timescale 1ns / 1ps

module tb_event_rule_trigger_table_top;
	import ertt_pkg::*;

	typedef struct {
		logic [2:0]  req;
		logic [15:0] id;
		logic [63:0] addr;
		logic [7:0]  ep;
		logic [15:0] attr;
		logic [2:0]  op;
		logic [31:0] thr;
		logic [7:0]  act;
		logic [31:0] smp;
	} request_t;

	typedef struct {
		logic [2:0]  st;
		logic [15:0] id;
		logic [7:0]  act;
		logic        lst;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_wdata = 0;
	logic start = 0;
	logic busy;
	logic [2:0] req_type = 0;
	logic [15:0] rule_id = 0;
	logic [63:0] dev_addr = 0;
	logic [7:0] endpoint = 0;
	logic [15:0] attr_code = 0;
	logic [2:0] op_code = 0;
	logic [31:0] threshold = 0;
	logic [7:0] action_type = 0;
	logic [31:0] sample = 0;
	logic strobe;
	logic [2:0] status;
	logic [15:0] fired_id;
	logic [7:0] fired_action;
	logic last;

	event_rule_trigger_table_top dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the rule table.
	logic [7:0]  hold_cfg;
	int          n_rules;
	request_t    rules[RULE_SLOTS];
	logic [7:0]  hold_cnt[RULE_SLOTS];

	request_t pending[$];
	answer_t  expected[$];
	int errors = 0;
	int n_events = 0, n_fired = 0;
	longint cycles = 0;

	function automatic int find_id(logic [15:0] id);
		for (int i = 0; i < n_rules; i++)
			if (rules[i].id == id)
				return i;
		return -1;
	endfunction

	function automatic void push(logic [2:0] st, logic [15:0] id, logic [7:0] act, logic l);
		answer_t a;
		a.st = st; a.id = id; a.act = act; a.lst = l;
		expected.push_back(a);
	endfunction

	function automatic void predict_table(request_t r);
		int k;
		case (r.req)
			REQ_ADD: begin
				if (n_rules >= RULE_SLOTS) begin
					push(ST_FULL, 0, 0, 1);
				end else begin
					rules[n_rules] = r;
					hold_cnt[n_rules] = 0;
					n_rules++;
					push(ST_OK, 0, 0, 1);
				end
			end
			REQ_EDIT: begin
				k = find_id(r.id);
				if (k < 0) begin
					push(ST_NOTFOUND, 0, 0, 1);
				end else begin
					rules[k] = r;
					hold_cnt[k] = 0;
					push(ST_OK, 0, 0, 1);
				end
			end
			REQ_REMOVE: begin
				k = find_id(r.id);
				if (k < 0) begin
					push(ST_NOTFOUND, 0, 0, 1);
				end else begin
					for (int i = k; i + 1 < n_rules; i++) begin
						rules[i] = rules[i + 1];
						hold_cnt[i] = hold_cnt[i + 1];
					end
					n_rules--;
					push(ST_OK, 0, 0, 1);
				end
			end
			REQ_EVENT: begin
				n_events++;
				for (int i = 0; i < n_rules; i++) begin
					logic hit;
					logic signed [31:0] a, b;
					a = r.smp; b = rules[i].thr;
					case (rules[i].op)
						OP_EQ: hit = a == b;
						OP_GT: hit = a > b;
						OP_LT: hit = a < b;
						OP_GE: hit = a >= b;
						OP_LE: hit = a <= b;
						default: hit = 0;
					endcase
					if (hold_cnt[i] == 0 && rules[i].addr == r.addr && rules[i].ep == r.ep
							&& rules[i].attr == r.attr && hit) begin
						hold_cnt[i] = hold_cfg;
						n_fired++;
						push(ST_FIRED, rules[i].id, rules[i].act, 0);
					end
				end
				push(ST_OK, 0, 0, 1);
			end
			REQ_TICK: begin
				for (int i = 0; i < RULE_SLOTS; i++)
					if (hold_cnt[i] != 0)
						hold_cnt[i]--;
				push(ST_TICK, 0, 0, 1);
			end
			default: ;
		endcase
	endfunction

	// Driver: one request at a time with a random gap before each.
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_table(pending.pop_front());
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
				if ($urandom_range(0, 2) == 0)
					gap = 0;
			end
			if (start && busy) begin
			end else if (gap > 0) begin
				gap--;
				start <= 0;
			end else if (pending.size() > 0 && !(start && !busy && pending.size() == 0)) begin
				start <= 1;
				req_type <= pending[0].req;
				rule_id <= pending[0].id;
				dev_addr <= pending[0].addr;
				endpoint <= pending[0].ep;
				attr_code <= pending[0].attr;
				op_code <= pending[0].op;
				threshold <= pending[0].thr;
				action_type <= pending[0].act;
				sample <= pending[0].smp;
			end else begin
				start <= 0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && strobe) begin
			if (expected.size() == 0) begin
				$display("%0t: unexpected result status=%0d id=%h act=%h last=%b",
					$time, status, fired_id, fired_action, last);
				errors++;
			end else begin
				answer_t e;
				e = expected.pop_front();
				if (e.st !== status || e.id !== fired_id || e.act !== fired_action
						|| e.lst !== last) begin
					$display("%0t: mismatch expected st=%0d id=%h act=%h last=%b, got st=%0d id=%h act=%h last=%b",
						$time, e.st, e.id, e.act, e.lst, status, fired_id, fired_action, last);
					errors++;
				end
			end
		end
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Small pools keep ids and addresses colliding often enough to fire rules.
	logic [63:0] addr_pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
		64'h8000_0000_0000_0001};

	function automatic request_t rand_req(logic [2:0] kind);
		request_t r;
		r.req = kind;
		r.id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		r.addr = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
			addr_pool[$urandom_range(0, 3)];
		r.ep = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1) * 255);
		r.attr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
		r.op = 3'($urandom_range(0, 7));
		r.thr = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 20)) - 10);
		r.act = 8'($urandom);
		r.smp = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 20)) - 10);
		return r;
	endfunction

	task automatic queue_req(logic [2:0] kind, logic [15:0] id, logic [2:0] op,
			logic [31:0] thr, logic [31:0] smp);
		request_t r;
		r = rand_req(kind);
		r.id = id; r.op = op; r.thr = thr; r.smp = smp;
		r.addr = addr_pool[1]; r.ep = 8'hFF; r.attr = 16'hFFFF;
		pending.push_back(r);
	endtask

	task automatic drain();
		while (pending.size() > 0 || start || expected.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_holdoff(logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		hold_cfg = v;
	endtask

	initial begin
		int pick;
		logic [7:0] settings[4] = '{8'd255, 8'd0, 8'd1, 8'd2};
		hold_cfg = 3;
		n_rules = 0;
		for (int i = 0; i < RULE_SLOTS; i++)
			hold_cnt[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, every comparison, full table, unknown ids, holdoff.
		queue_req(REQ_REMOVE, 16'hFFFF, OP_EQ, 0, 0);
		queue_req(REQ_EDIT, 16'h0000, OP_EQ, 0, 0);
		queue_req(REQ_ADD, 16'hFFFF, OP_EQ, 32'h8000_0000, 0);
		queue_req(REQ_ADD, 16'h0001, OP_GT, 32'h7FFF_FFFF, 0);
		queue_req(REQ_ADD, 16'h0002, OP_LT, 32'h0, 0);
		queue_req(REQ_ADD, 16'h0003, OP_GE, 32'hFFFF_FFFF, 0);
		queue_req(REQ_ADD, 16'h0004, OP_LE, 32'h8000_0000, 0);
		queue_req(REQ_ADD, 16'h0005, 3'd7, 32'h0, 0);
		queue_req(REQ_EVENT, 0, 0, 0, 32'h8000_0000);
		queue_req(REQ_EVENT, 0, 0, 0, 32'h7FFF_FFFF);
		queue_req(REQ_TICK, 0, 0, 0, 0);
		queue_req(REQ_EVENT, 0, 0, 0, 32'hFFFF_FFFF);
		queue_req(REQ_TICK, 0, 0, 0, 0);
		queue_req(REQ_TICK, 0, 0, 0, 0);
		queue_req(REQ_EDIT, 16'h0003, OP_GE, 32'h0, 0);
		queue_req(REQ_REMOVE, 16'h0002, OP_EQ, 0, 0);
		queue_req(3'd5, 0, 0, 0, 0);
		queue_req(3'd7, 0, 0, 0, 0);
		queue_req(REQ_EVENT, 0, 0, 0, 32'h0);
		for (int i = 0; i < 12; i++)
			queue_req(REQ_ADD, 16'h0001, OP_EQ, 0, 0);
		drain();

		// Random phases, each with its own holdoff setting.
		for (int ph = 0; ph < 4; ph++) begin
			set_holdoff(settings[ph]);
			for (int n = 0; n < 88; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 22) pending.push_back(rand_req(REQ_ADD));
				else if (pick < 32) pending.push_back(rand_req(REQ_EDIT));
				else if (pick < 50) pending.push_back(rand_req(REQ_REMOVE));
				else if (pick < 80) pending.push_back(rand_req(REQ_EVENT));
				else if (pick < 97) pending.push_back(rand_req(REQ_TICK));
				else pending.push_back(rand_req(3'($urandom_range(5, 7))));
				if (n == 40)
					drain();
			end
			drain();
		end

		$display("Ran %0d events with %0d rule firings across four holdoff settings.",
			n_events, n_fired);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
